// File: rtl/core/ssfe_pkg.sv
// Shared types, constants and digit helpers for the seven-segment frame encoder.
package ssfe_pkg;

  localparam int VALUE_W   = 20;
  localparam int Q_W       = 11;  // value / 1000 fits in 11 bits
  localparam int R_W       = 10;  // remainder below 1000
  localparam int REM_W     = 7;   // remainder below 100
  localparam int DIG_W     = 4;
  localparam int FRAME_LEN = 9;
  localparam int CNT_W     = 4;
  localparam int IN_DATA_W = 24;

  localparam logic [20:0] RECIP_1000  = 21'd1073742;  // ceil(2^30 / 1000)
  localparam int          RECIP_SHIFT = 30;
  localparam int          PROD_W      = VALUE_W + 21;

  localparam logic [7:0] ADDR_BYTE  = 8'h08;
  localparam logic [7:0] CTRL_BYTE  = 8'h18;
  localparam logic [7:0] BRIGHT_HI  = 8'hFF;
  localparam logic [7:0] BRIGHT_LO  = 8'hF9;
  localparam logic [7:0] BLANK_CODE = 8'h00;

  typedef enum logic [1:0] {
    LAYOUT_SIX   = 2'd0,
    LAYOUT_THREE = 2'd1,
    LAYOUT_FOUR  = 2'd2,
    LAYOUT_NONE  = 2'd3
  } layout_t;

  typedef struct packed {
    layout_t layout;
    logic    bright;
  } ssfe_tag_t;

  // digits handed from the split pipeline to the frame builder
  typedef struct packed {
    ssfe_tag_t              tag;
    logic [Q_W-1:0]         q;     // value / 1000
    logic [DIG_W-1:0]       hq;    // value / 100000 (0..10)
    logic [DIG_W-1:0]       tq;    // (value / 10000) % 10
    logic [DIG_W-1:0]       uq;    // (value / 1000) % 10
    logic [DIG_W-1:0]       hr;    // (value / 100) % 10
    logic [REM_W-1:0]       remr;  // value % 100
  } ssfe_dig_t;

  function automatic logic [7:0] seg_code(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h3F;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5B;
      4'd3:    c = 8'h4F;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h7D;
      4'd7:    c = 8'h07;
      4'd8:    c = 8'h7F;
      4'd9:    c = 8'h6F;
      default: c = BLANK_CODE;
    endcase
    return c;
  endfunction

  // tens and units of a value below 100
  function automatic logic [2*DIG_W-1:0] split99(input logic [REM_W-1:0] x);
    logic [DIG_W-1:0] t;
    logic [REM_W-1:0] u;
    t = '0;
    for (int k = 1; k < 10; k++) begin
      t = t + DIG_W'(x >= REM_W'(k * 10));
    end
    u = x - REM_W'(t) * REM_W'(10);
    return {t, u[DIG_W-1:0]};
  endfunction

  // hundreds of a value up to 1048 (result 0..10)
  function automatic logic [DIG_W-1:0] hund_q(input logic [Q_W-1:0] x);
    logic [DIG_W-1:0] h;
    h = '0;
    for (int k = 1; k <= 10; k++) begin
      h = h + DIG_W'(x >= Q_W'(k * 100));
    end
    return h;
  endfunction

  // hundreds of a value below 1000
  function automatic logic [DIG_W-1:0] hund_r(input logic [R_W-1:0] x);
    logic [DIG_W-1:0] h;
    h = '0;
    for (int k = 1; k < 10; k++) begin
      h = h + DIG_W'(x >= R_W'(k * 100));
    end
    return h;
  endfunction

endpackage

// File: rtl/core/ssfe_split.sv
// Decimal digit split pipeline: input register, divide by 1000, hundreds, tens and units.
module ssfe_split import ssfe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  layout_t             in_layout,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                in_bright,
  output logic                dig_valid,
  input  logic                dig_ready,
  output ssfe_dig_t           dig
);

  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;

  ssfe_tag_t          r0_tag;
  logic [VALUE_W-1:0] r0_value;

  ssfe_tag_t          r1_tag;
  logic [Q_W-1:0]     r1_q;
  logic [R_W-1:0]     r1_vlo;

  ssfe_tag_t          r2_tag;
  logic [Q_W-1:0]     r2_q;
  logic [DIG_W-1:0]   r2_hq;
  logic [REM_W-1:0]   r2_remq;
  logic [R_W-1:0]     r2_r;

  ssfe_dig_t          r3_dig;

  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_next;
  logic [Q_W-1:0]     q_k;
  logic [R_W-1:0]     r_next;
  logic [DIG_W-1:0]   hq_next;
  logic [REM_W-1:0]   remq_next;
  logic [2*DIG_W-1:0] tuq;
  logic [DIG_W-1:0]   hr_next;
  ssfe_dig_t          dig_next;

  assign rdy3     = !v3 || dig_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  // stage 1: reciprocal multiply for value / 1000
  assign prod   = PROD_W'(r0_value) * PROD_W'(RECIP_1000);
  assign q_next = prod[RECIP_SHIFT +: Q_W];

  // stage 2: remainder and hundreds of the quotient
  assign q_k       = r1_q * Q_W'(1000);
  assign r_next    = r1_vlo - q_k[R_W-1:0];
  assign hq_next   = hund_q(r1_q);
  assign remq_next = REM_W'(r1_q - Q_W'(hq_next) * Q_W'(100));

  // stage 3: remaining digits
  assign tuq     = split99(r2_remq);
  assign hr_next = hund_r(r2_r);

  always_comb begin
    dig_next      = '0;
    dig_next.tag  = r2_tag;
    dig_next.q    = r2_q;
    dig_next.hq   = r2_hq;
    dig_next.tq   = tuq[2*DIG_W-1:DIG_W];
    dig_next.uq   = tuq[DIG_W-1:0];
    dig_next.hr   = hr_next;
    dig_next.remr = REM_W'(r2_r - R_W'(hr_next) * R_W'(100));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid && (in_layout != LAYOUT_NONE);
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      r0_tag.layout <= in_layout;
      r0_tag.bright <= in_bright;
      r0_value      <= in_value;
    end
    if (rdy1) begin
      r1_tag <= r0_tag;
      r1_q   <= q_next;
      r1_vlo <= r0_value[R_W-1:0];
    end
    if (rdy2) begin
      r2_tag  <= r1_tag;
      r2_q    <= r1_q;
      r2_hq   <= hq_next;
      r2_remq <= remq_next;
      r2_r    <= r_next;
    end
    if (rdy3) begin
      r3_dig <= dig_next;
    end
  end

  assign dig_valid = v3;
  assign dig       = r3_dig;

  a_q_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (r1_q <= Q_W'(1048)))
    else $error("quotient by 1000 out of range");

  a_r_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (r2_r < R_W'(1000)) && (r2_remq < REM_W'(100)))
    else $error("remainder out of range");

  a_dig_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !dig_ready) |=> (v3 && $stable(r3_dig)))
    else $error("digit stage lost data under stall");

  a_no_none: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (r0_tag.layout != LAYOUT_NONE))
    else $error("undefined layout entered pipeline");

endmodule

// File: rtl/core/ssfe_frame.sv
// Frame builder and byte serializer: digits to segment codes, one frame byte per beat.
module ssfe_frame import ssfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        dig_valid,
  output logic        dig_ready,
  input  ssfe_dig_t   dig,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_port,
  output logic        out_last
);

  logic [FRAME_LEN-1:0][7:0] frame;
  logic [CNT_W-1:0]          cnt;
  logic                      port;

  logic [FRAME_LEN-1:0][7:0] full;
  logic [FRAME_LEN-1:0][7:0] frame_next;
  logic [CNT_W-1:0]          len_full;
  logic [CNT_W-1:0]          cnt_next;
  logic                      omit;
  logic [2*DIG_W-1:0]        tur;
  logic [7:0]                br_byte;
  logic                      load;
  logic                      beat;

  assign tur     = split99(dig.remr);
  assign br_byte = dig.tag.bright ? BRIGHT_HI : BRIGHT_LO;

  always_comb begin
    full     = '0;
    len_full = '0;
    omit     = 1'b0;
    full[0]  = ADDR_BYTE;
    case (dig.tag.layout)
      LAYOUT_SIX: begin
        full[1]  = seg_code(dig.hq);
        full[2]  = seg_code(dig.tq);
        full[3]  = seg_code(dig.uq);
        full[4]  = seg_code(dig.hr);
        full[5]  = seg_code(tur[2*DIG_W-1:DIG_W]);
        full[6]  = seg_code(tur[DIG_W-1:0]);
        full[7]  = CTRL_BYTE;
        full[8]  = br_byte;
        len_full = CNT_W'(9);
      end
      LAYOUT_THREE: begin
        // leading digit is value / 100
        if (dig.q == '0) begin
          full[1] = seg_code(dig.hr);
        end else if (dig.q == Q_W'(1) && dig.hr == '0) begin
          full[1] = BLANK_CODE;
        end else begin
          omit = 1'b1;
        end
        full[2]  = seg_code(tur[2*DIG_W-1:DIG_W]);
        full[3]  = seg_code(tur[DIG_W-1:0]);
        full[4]  = BLANK_CODE;
        full[5]  = BLANK_CODE;
        full[6]  = BLANK_CODE;
        full[7]  = CTRL_BYTE;
        full[8]  = br_byte;
        len_full = CNT_W'(9);
      end
      LAYOUT_FOUR: begin
        if (dig.q < Q_W'(10)) begin
          full[1] = seg_code(dig.q[DIG_W-1:0]);
        end else if (dig.q == Q_W'(10)) begin
          full[1] = BLANK_CODE;
        end else begin
          omit = 1'b1;
        end
        full[2]  = seg_code(dig.hr);
        full[3]  = seg_code(tur[2*DIG_W-1:DIG_W]);
        full[4]  = seg_code(tur[DIG_W-1:0]);
        full[5]  = CTRL_BYTE;
        full[6]  = br_byte;
        len_full = CNT_W'(7);
      end
      default: begin
        len_full = '0;
      end
    endcase
  end

  always_comb begin
    frame_next = full;
    cnt_next   = len_full;
    if (omit) begin
      for (int i = 1; i < FRAME_LEN - 1; i++) begin
        frame_next[i] = full[i+1];
      end
      frame_next[FRAME_LEN-1] = '0;
      cnt_next = len_full - CNT_W'(1);
    end
  end

  assign out_valid = (cnt != '0);
  assign out_byte  = frame[0];
  assign out_port  = port;
  assign out_last  = (cnt == CNT_W'(1));
  assign beat      = out_valid && out_ready;
  assign dig_ready = !out_valid || (out_ready && out_last);
  assign load      = dig_valid && dig_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= cnt_next;
    end else if (beat) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_next;
      port  <= (dig.tag.layout == LAYOUT_FOUR);
    end else if (beat) begin
      frame <= {8'h00, frame[FRAME_LEN-1:1]};
    end
  end

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (beat && out_last && !load) |=> !out_valid)
    else $error("beats continue after last");

  a_len: assert property (@(posedge clk) disable iff (rst)
    load |=> (cnt >= CNT_W'(6)) && (cnt <= CNT_W'(FRAME_LEN)))
    else $error("frame length out of range");

  a_port: assert property (@(posedge clk) disable iff (rst)
    (beat && !out_last) |=> $stable(port))
    else $error("port changed within a frame");

  a_addr_first: assert property (@(posedge clk) disable iff (rst)
    load |=> (frame[0] == ADDR_BYTE))
    else $error("frame does not open with address byte");

endmodule

// File: rtl/core/seven_segment_frame_encoder_top.sv
// Seven-segment frame encoder top level.
// An input beat passes the input, quotient, hundreds and digit registers, then loads the
// serializer register. Throughput: one output byte per cycle while m_axis_tready is high;
// a frame takes 9 beats (six- and three-digit layouts) or 7 beats (four-digit), one fewer
// when the leading digit is dropped; steady state takes one input beat per frame, the four
// split stages buffer up to four requests, and an ignored layout is accepted and dropped.
// Reset (rst, synchronous) clears pipeline valid bits and the byte count only.
module seven_segment_frame_encoder_top import ssfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [19:0] value, [20] bright, [23:21] zero
  input  logic [1:0]            s_axis_tuser,   // [1:0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] data_byte
  output logic                  m_axis_tuser,   // [0] port
  output logic                  m_axis_tlast
);

  logic      dig_valid;
  logic      dig_ready;
  ssfe_dig_t dig;

  ssfe_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_layout (layout_t'(s_axis_tuser)),
    .in_value  (s_axis_tdata[VALUE_W-1:0]),
    .in_bright (s_axis_tdata[VALUE_W]),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  ssfe_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_port  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule
